// ===== design/box_corner_roll_pitch_transform_assert.svh =====
// Assertion macros shared by the box corner transform RTL.
`ifndef BOX_CORNER_ROLL_PITCH_TRANSFORM_ASSERT_SVH
`define BOX_CORNER_ROLL_PITCH_TRANSFORM_ASSERT_SVH
`ifndef SYNTHESIS
`define BCRPT_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
    else $error("assertion failed");
`define BCRPT_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define BCRPT_ASSERT(lbl, clk_s, rst_s, prop)
`define BCRPT_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

// ===== design/bcrpt_pkg.sv =====
`default_nettype none
package bcrpt_pkg;

  localparam int CordicSteps = 24;
  localparam int NumRegs     = 3;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 31;

  localparam logic [CfgIdxW-1:0] RegBoxWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegBoxHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegBoxDepth  = 2'd2;

  localparam logic [CfgDataW-1:0] BoxReset = 31'd65536;

  localparam logic signed [15:0] ScaleQ14   = 16'sd22118;
  localparam logic signed [31:0] TurnPerRad = 32'sd683565276;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  typedef logic signed [33:0] atan_tab_t [CordicSteps];
  localparam atan_tab_t AtanTurns = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
    34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772,
    34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861,
    34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304,
    34'sd652, 34'sd326, 34'sd163, 34'sd81
  };

  typedef struct packed {
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
  } req_t;

  typedef struct packed {
    logic [2:0]         corner_index;
    logic signed [31:0] corner_x;
    logic signed [31:0] corner_y;
    logic signed [31:0] corner_z;
    logic               last_corner;
  } res_t;

  typedef struct packed {
    logic [1:0]         quad;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } lane_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    lane_t              pitch;
    lane_t              roll;
  } stage_t;

  function automatic lane_t cordic_iter(lane_t l, int unsigned sh, logic signed [33:0] atn);
    lane_t r;
    r.quad = l.quad;
    if (!l.z[33]) begin
      r.x = l.x - (l.y >>> sh);
      r.y = l.y + (l.x >>> sh);
      r.z = l.z - atn;
    end else begin
      r.x = l.x + (l.y >>> sh);
      r.y = l.y - (l.x >>> sh);
      r.z = l.z + atn;
    end
    return r;
  endfunction

  // Add one half LSB and floor shift by 30.
  function automatic logic signed [33:0] round30(logic signed [68:0] v);
    logic signed [68:0] t;
    t = v + (69'sd1 <<< 29);
    return t[63:30];
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [34:0] v);
    if (v > 35'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -35'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/bcrpt_cordic_cell.sv =====
`default_nettype none
module bcrpt_cordic_cell #(
  parameter int Shift = 0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bcrpt_pkg::stage_t in_st,
  output bcrpt_pkg::stage_t      out_st
);

  bcrpt_pkg::stage_t st_r, st_nxt;

  // Both angles take one micro-rotation at the same shift.
  always_comb begin
    st_nxt       = in_st;
    st_nxt.pitch = bcrpt_pkg::cordic_iter(in_st.pitch, Shift, bcrpt_pkg::AtanTurns[Shift]);
    st_nxt.roll  = bcrpt_pkg::cordic_iter(in_st.roll, Shift, bcrpt_pkg::AtanTurns[Shift]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign out_st = st_r;

endmodule
`default_nettype wire

// ===== design/bcrpt_corner.sv =====
`default_nettype none
`include "box_corner_roll_pitch_transform_assert.svh"
module bcrpt_corner (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire bcrpt_pkg::stage_t                 in_st,
  input  wire logic [bcrpt_pkg::CfgDataW-1:0]    box_width,
  input  wire logic [bcrpt_pkg::CfgDataW-1:0]    box_height,
  input  wire logic [bcrpt_pkg::CfgDataW-1:0]    box_depth,
  output logic                                   out_valid,
  output bcrpt_pkg::res_t                        out_res
);

  // Angle terms of the current job after quadrant folding.
  logic signed [33:0] cp_r, sp_r, cr_r, sr_r;
  logic signed [31:0] ox_r, oy_r, oz_r;
  logic               run_r, run_nxt;
  logic [2:0]         k_r, k_nxt;
  logic signed [33:0] c_p, s_p, c_r, s_r;

  function automatic logic signed [67:0] fold(bcrpt_pkg::lane_t l);
    logic signed [33:0] c, s;
    case (l.quad)
      2'd0: begin c = l.x;  s = l.y;  end
      2'd1: begin c = -l.y; s = l.x;  end
      2'd2: begin c = -l.x; s = -l.y; end
      default: begin c = l.y; s = -l.x; end
    endcase
    return {c, s};
  endfunction

  assign {c_p, s_p} = fold(in_st.pitch);
  assign {c_r, s_r} = fold(in_st.roll);

  always_comb begin
    run_nxt = run_r;
    k_nxt   = k_r;
    if (in_st.valid) begin
      run_nxt = 1'b1;
      k_nxt   = 3'd0;
    end else if (run_r) begin
      k_nxt = k_r + 3'd1;
      if (k_r == 3'd7) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      k_r   <= 3'd0;
    end else begin
      run_r <= run_nxt;
      k_r   <= k_nxt;
    end
    if (in_st.valid) begin
      cp_r <= c_p;
      sp_r <= s_p;
      cr_r <= c_r;
      sr_r <= s_r;
      ox_r <= in_st.ox;
      oy_r <= in_st.oy;
      oz_r <= in_st.oz;
    end
  end

  // Corner vertex from the index bits.
  logic signed [31:0] hx, hy, hz, vx, vy, vz;
  assign hx = {2'b00, box_width[30:1]};
  assign hy = {2'b00, box_height[30:1]};
  assign hz = {2'b00, box_depth[30:1]};
  assign vx = k_r[1] ? hx : -hx;
  assign vy = k_r[0] ? hy : -hy;
  assign vz = k_r[2] ? hz : -hz;

  // Stage A: roll products.
  logic               va_r;
  logic [2:0]         ka_r;
  logic signed [65:0] pxc_r, pys_r, pxs_r, pyc_r;
  logic signed [31:0] vza_r, oxa_r, oya_r, oza_r;
  logic signed [33:0] cpa_r, spa_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= run_r;
    end
    ka_r  <= k_r;
    pxc_r <= vx * cr_r;
    pys_r <= vy * sr_r;
    pxs_r <= vx * sr_r;
    pyc_r <= vy * cr_r;
    vza_r <= vz;
    oxa_r <= ox_r;
    oya_r <= oy_r;
    oza_r <= oz_r;
    cpa_r <= cp_r;
    spa_r <= sp_r;
  end

  // Stage B: round the rolled X and Y.
  logic               vb_r;
  logic [2:0]         kb_r;
  logic signed [33:0] x1b_r, y1b_r, cpb_r, spb_r;
  logic signed [31:0] vzb_r, oxb_r, oyb_r, ozb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
    kb_r  <= ka_r;
    x1b_r <= bcrpt_pkg::round30(69'(pxc_r) - 69'(pys_r));
    y1b_r <= bcrpt_pkg::round30(69'(pxs_r) + 69'(pyc_r));
    cpb_r <= cpa_r;
    spb_r <= spa_r;
    vzb_r <= vza_r;
    oxb_r <= oxa_r;
    oyb_r <= oya_r;
    ozb_r <= oza_r;
  end

  // Stage C: pitch products.
  logic               vc_r;
  logic [2:0]         kc_r;
  logic signed [67:0] ycp_r, zsp_r, ysp_r, zcp_r;
  logic signed [33:0] x1c_r;
  logic signed [31:0] oxc_r, oyc_r, ozc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else begin
      vc_r <= vb_r;
    end
    kc_r  <= kb_r;
    ycp_r <= y1b_r * cpb_r;
    zsp_r <= 68'(vzb_r * spb_r);
    ysp_r <= y1b_r * spb_r;
    zcp_r <= 68'(vzb_r * cpb_r);
    x1c_r <= x1b_r;
    oxc_r <= oxb_r;
    oyc_r <= oyb_r;
    ozc_r <= ozb_r;
  end

  // Stage D: round, add the offset and saturate.
  logic signed [33:0] y2, z2;
  logic               vd_r;
  bcrpt_pkg::res_t    res_r;

  assign y2 = bcrpt_pkg::round30(69'(ycp_r) - 69'(zsp_r));
  assign z2 = bcrpt_pkg::round30(69'(ysp_r) + 69'(zcp_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else begin
      vd_r <= vc_r;
    end
    res_r.corner_index <= kc_r;
    res_r.corner_x     <= bcrpt_pkg::sat32(35'(x1c_r) + 35'(oxc_r));
    res_r.corner_y     <= bcrpt_pkg::sat32(35'(y2) + 35'(oyc_r));
    res_r.corner_z     <= bcrpt_pkg::sat32(35'(z2) + 35'(ozc_r));
    res_r.last_corner  <= (kc_r == 3'd7);
  end

  assign out_valid = vd_r;
  assign out_res   = res_r;

  `BCRPT_ASSERT_IMPLY(a_job_no_overlap, clk, rst_n, in_st.valid && run_r, k_r == 3'd7)
  `BCRPT_ASSERT_IMPLY(a_run_steps, clk, rst_n, run_r && k_r != 3'd7 && !in_st.valid, ##1 (run_r && k_r == $past(k_r) + 3'd1))
  `BCRPT_ASSERT_IMPLY(a_out_follows, clk, rst_n, run_r, ##4 out_valid)

endmodule
`default_nettype wire

// ===== design/box_corner_roll_pitch_transform.sv =====
`default_nettype none
`include "box_corner_roll_pitch_transform_assert.svh"
// Box corner roll/pitch transform. A request (position plus pitch and roll
// angles) is taken with start while busy is low, and produces eight corner
// results on consecutive cycles, each marked by out_valid, the eighth with
// last_corner set. The receiver cannot stall: every result is on the
// out_ ports for exactly one cycle and must be taken then. A new request can
// be taken while earlier ones are still in the pipeline, once busy is low;
// busy rises after each transfer and is held so that each request reaches
// the single corner datapath just as the previous one's corners finish.
// The first corner comes out after phase preparation, 24 CORDIC cells and
// a five stage corner datapath. Configuration writes take effect at once and
// must be made while no request is in flight.
module box_corner_roll_pitch_transform (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire bcrpt_pkg::req_t                in_req,
  output logic                                out_valid,
  output bcrpt_pkg::res_t                     out_res,
  input  wire logic                           cfg_we,
  input  wire logic [bcrpt_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [bcrpt_pkg::CfgDataW-1:0] cfg_data
);

  // Configuration registers. Unknown indexes are ignored.
  logic [bcrpt_pkg::CfgDataW-1:0] width_r, height_r, depth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bcrpt_pkg::BoxReset;
      height_r <= bcrpt_pkg::BoxReset;
      depth_r  <= bcrpt_pkg::BoxReset;
    end else if (cfg_we) begin
      case (cfg_index)
        bcrpt_pkg::RegBoxWidth:  width_r  <= cfg_data;
        bcrpt_pkg::RegBoxHeight: height_r <= cfg_data;
        bcrpt_pkg::RegBoxDepth:  depth_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request spacing counter, loaded on a transfer, so each request reaches
  // the corner datapath just as the previous one finishes.
  logic [2:0] busy_cnt_r, busy_cnt_nxt;
  logic       accept;

  assign accept = start && !busy;
  assign busy   = (busy_cnt_r != 3'd0);

  always_comb begin
    busy_cnt_nxt = busy_cnt_r;
    if (accept) begin
      busy_cnt_nxt = 3'd7;
    end else if (busy) begin
      busy_cnt_nxt = busy_cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_cnt_r <= 3'd0;
    end else begin
      busy_cnt_r <= busy_cnt_nxt;
    end
  end

  // Phase stage one: scale and negate each angle, units of 2^-26 radian.
  logic               p1_valid_r;
  logic signed [31:0] p1_tp_r, p1_tr_r, p1_ox_r, p1_oy_r, p1_oz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= accept;
    end
    p1_tp_r <= -(32'(in_req.pitch_angle * bcrpt_pkg::ScaleQ14));
    p1_tr_r <= -(32'(in_req.roll_angle * bcrpt_pkg::ScaleQ14));
    p1_ox_r <= in_req.offset_x;
    p1_oy_r <= in_req.offset_y;
    p1_oz_r <= in_req.offset_z;
  end

  // Phase stage two: convert to a 32 bit turn phase, fold it into the
  // quadrant nearest zero and load the CORDIC start vector.
  function automatic bcrpt_pkg::lane_t start_lane(logic signed [31:0] t);
    logic signed [63:0] prod;
    logic [31:0]        phase;
    logic [31:0]        bump;
    logic [31:0]        u;
    bcrpt_pkg::lane_t   l;
    prod   = t * bcrpt_pkg::TurnPerRad;
    phase  = prod[57:26];
    bump   = phase + 32'h2000_0000;
    l.quad = bump[31:30];
    u      = phase - {l.quad, 30'd0};
    l.z    = {{2{u[31]}}, u};
    l.x    = bcrpt_pkg::CordicGain;
    l.y    = '0;
    return l;
  endfunction

  bcrpt_pkg::stage_t chain [bcrpt_pkg::CordicSteps+1];
  bcrpt_pkg::stage_t p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_r.valid <= 1'b0;
    end else begin
      p2_r.valid <= p1_valid_r;
    end
    p2_r.ox    <= p1_ox_r;
    p2_r.oy    <= p1_oy_r;
    p2_r.oz    <= p1_oz_r;
    p2_r.pitch <= start_lane(p1_tp_r);
    p2_r.roll  <= start_lane(p1_tr_r);
  end

  assign chain[0] = p2_r;

  // One CORDIC micro-rotation per cell, both angles side by side.
  for (genvar i = 0; i < bcrpt_pkg::CordicSteps; i++) begin : g_cell
    bcrpt_cordic_cell #(.Shift(i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .in_st (chain[i]),
      .out_st(chain[i+1])
    );
  end

  bcrpt_corner u_corner (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_st     (chain[bcrpt_pkg::CordicSteps]),
    .box_width (width_r),
    .box_height(height_r),
    .box_depth (depth_r),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  `BCRPT_ASSERT_IMPLY(a_busy_after_transfer, clk, rst_n, accept, ##1 busy)
  `BCRPT_ASSERT_IMPLY(a_busy_releases, clk, rst_n, accept, ##8 !busy)
  `BCRPT_ASSERT_IMPLY(a_burst_continues, clk, rst_n, out_valid && !out_res.last_corner, ##1 (out_valid && out_res.corner_index == $past(out_res.corner_index) + 3'd1))

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Testbench for the box corner roll/pitch transform.
// Requests go in through the start/busy command port; every accepted request
// yields eight corner transfers that are checked, field by field and in order,
// against a behavioral model of the rotation kept in this file. The box
// registers are rewritten between phases, only once every outstanding corner
// has come out, so the model and the block always agree on the box size.
module tb_top;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  bcrpt_pkg::req_t in_req;
  logic out_valid;
  bcrpt_pkg::res_t out_res;
  logic cfg_we;
  logic [bcrpt_pkg::CfgIdxW-1:0] cfg_index;
  logic [bcrpt_pkg::CfgDataW-1:0] cfg_data;

  box_corner_roll_pitch_transform dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Local copy of the box registers, updated together with every write.
  logic [30:0] model_width;
  logic [30:0] model_height;
  logic [30:0] model_depth;

  // Corners still owed by the block, oldest first.
  bcrpt_pkg::res_t corner_q[$];
  int error_count;

  task automatic report_mismatch(input string what);
    error_count++;
    $display("tb_top: mismatch at %0t: %s", $realtime, what);
  endtask

  // CORDIC sine and cosine of -1.35 times a Q4.12 angle, both in Q2.30.
  // The angle is first turned into a 32-bit phase of a full turn, so any
  // angle wraps, then folded into the quadrant around zero.
  task automatic scaled_sin_cos(input logic signed [15:0] ang,
                                output longint c, output longint s);
    longint t;
    bit [63:0] prod;
    bit [31:0] phase;
    bit [31:0] qsum;
    bit [1:0] quad;
    bit [31:0] u;
    longint x, y, z, nx;
    t = -(longint'(ang) * 64'sd22118);
    prod = t * 64'd683565276;
    phase = prod[57:26];
    qsum = (phase + 32'h2000_0000) >> 30;
    quad = qsum[1:0];
    u = phase - {quad, 30'b0};
    z = longint'($signed(u));
    x = longint'(bcrpt_pkg::CordicGain);
    y = 0;
    for (int i = 0; i < bcrpt_pkg::CordicSteps; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - longint'(bcrpt_pkg::AtanTurns[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + longint'(bcrpt_pkg::AtanTurns[i]);
      end
      x = nx;
    end
    case (quad)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  function automatic longint round_q30(input longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Rolls and pitches the eight box corners and queues what the block owes.
  task automatic queue_corners(input bcrpt_pkg::req_t r);
    longint cp, sp, cr, sr;
    longint hx, hy, hz, vx, vy, vz, x1, y1, y2, z2;
    bcrpt_pkg::res_t c;
    scaled_sin_cos(r.pitch_angle, cp, sp);
    scaled_sin_cos(r.roll_angle, cr, sr);
    hx = longint'(model_width >> 1);
    hy = longint'(model_height >> 1);
    hz = longint'(model_depth >> 1);
    for (int k = 0; k < 8; k++) begin
      vx = k[1] ? hx : -hx;
      vy = k[0] ? hy : -hy;
      vz = k[2] ? hz : -hz;
      x1 = round_q30(vx * cr - vy * sr);
      y1 = round_q30(vx * sr + vy * cr);
      y2 = round_q30(y1 * cp - vz * sp);
      z2 = round_q30(y1 * sp + vz * cp);
      c.corner_index = k[2:0];
      c.corner_x = clamp32(x1 + longint'(r.offset_x));
      c.corner_y = clamp32(y2 + longint'(r.offset_y));
      c.corner_z = clamp32(z2 + longint'(r.offset_z));
      c.last_corner = (k == 7);
      corner_q.push_back(c);
    end
  endtask

  // Every corner transfer is taken at the rising edge; nothing can hold it.
  always @(posedge clk) begin
    bcrpt_pkg::res_t want;
    if (rst_n && out_valid) begin
      if (corner_q.size() == 0) begin
        report_mismatch("corner with nothing outstanding");
      end else begin
        want = corner_q.pop_front();
        if (out_res.corner_index !== want.corner_index)
          report_mismatch($sformatf("corner_index %0d, want %0d",
                                    out_res.corner_index, want.corner_index));
        if (out_res.corner_x !== want.corner_x)
          report_mismatch($sformatf("corner %0d x %h, want %h",
                                    want.corner_index, out_res.corner_x, want.corner_x));
        if (out_res.corner_y !== want.corner_y)
          report_mismatch($sformatf("corner %0d y %h, want %h",
                                    want.corner_index, out_res.corner_y, want.corner_y));
        if (out_res.corner_z !== want.corner_z)
          report_mismatch($sformatf("corner %0d z %h, want %h",
                                    want.corner_index, out_res.corner_z, want.corner_z));
        if (out_res.last_corner !== want.last_corner)
          report_mismatch($sformatf("corner %0d last flag %b, want %b",
                                    want.corner_index, out_res.last_corner,
                                    want.last_corner));
      end
    end
  end

  // Register writes happen only while no request is in flight.
  task automatic write_reg(input logic [bcrpt_pkg::CfgIdxW-1:0] idx,
                           input logic [30:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    case (idx)
      bcrpt_pkg::RegBoxWidth: model_width = val;
      bcrpt_pkg::RegBoxHeight: model_height = val;
      bcrpt_pkg::RegBoxDepth: model_depth = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Most gaps between requests are none, many are short, a few are long.
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(99);
    if (sel < 55) return 0;
    if (sel < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Holds start high from the falling edge until the request is taken,
  // then keeps it high for the next one or lowers it for a gap.
  task automatic send_request(input bcrpt_pkg::req_t r);
    int gap;
    start = 1'b1;
    in_req = r;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    queue_corners(r);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      in_req = {$urandom, $urandom, $urandom, $urandom};
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Waits out every outstanding corner, then the pipeline tail.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (corner_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_angle();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(16000)) - 8000);
  endfunction

  function automatic logic signed [31:0] rand_offset();
    int sel;
    sel = $urandom_range(9);
    if (sel < 6) return $signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
    if (sel < 8) return 32'($urandom);
    return sel[0] ? 32'sh7FF0_0000 + $urandom_range(32'hF_FFFF)
                  : 32'sh8000_0000 + $urandom_range(32'hF_FFFF);
  endfunction

  function automatic bcrpt_pkg::req_t rand_request();
    bcrpt_pkg::req_t r;
    r.offset_x = rand_offset();
    r.offset_y = rand_offset();
    r.offset_z = rand_offset();
    r.pitch_angle = rand_angle();
    r.roll_angle = rand_angle();
    return r;
  endfunction

  // Directed rows: zero attitude, angle extremes in each field, a quarter
  // turn, a large angle that wraps past a full turn, and offsets at both ends
  // so that every axis saturates.
  typedef struct {
    logic signed [31:0] ox, oy, oz;
    logic signed [15:0] pitch, roll;
  } stim_row_t;

  localparam int NumRows = 12;
  stim_row_t stim_table [NumRows] = '{
    '{32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0},
    '{32'sd65536, -32'sd65536, 32'sd131072, 16'sd0, 16'sd0},
    '{32'sd0, 32'sd0, 32'sd0, 16'sd4766, 16'sd0},
    '{32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd4766},
    '{32'sd0, 32'sd0, 32'sd0, -16'sd4766, -16'sd4766},
    '{32'sd0, 32'sd0, 32'sd0, 16'sh7FFF, 16'sh7FFF},
    '{32'sd0, 32'sd0, 32'sd0, -16'sh8000, -16'sh8000},
    '{32'sd0, 32'sd0, 32'sd0, 16'sh7FFF, -16'sh8000},
    '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sd0, 16'sd0},
    '{-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000, 16'sd0, 16'sd0},
    '{32'sh7FFF_FFFF, -32'sh8000_0000, 32'sd12345, 16'sd1000, -16'sd2000},
    '{-32'sd1, 32'sd1, -32'sd1, -16'sd1, 16'sd1}
  };

  initial begin
    bcrpt_pkg::req_t r;
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    cfg_we = 1'b0;
    cfg_index = bcrpt_pkg::RegBoxWidth;
    cfg_data = '0;
    error_count = 0;
    model_width = bcrpt_pkg::BoxReset;
    model_height = bcrpt_pkg::BoxReset;
    model_depth = bcrpt_pkg::BoxReset;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part with the registers at their reset value.
    foreach (stim_table[i]) begin
      r.offset_x = stim_table[i].ox;
      r.offset_y = stim_table[i].oy;
      r.offset_z = stim_table[i].oz;
      r.pitch_angle = stim_table[i].pitch;
      r.roll_angle = stim_table[i].roll;
      send_request(r);
    end
    // Offsets at the extremes saturate the positive corner of a unit box at
    // zero attitude; these expectations are read straight off the geometry.
    r = '{offset_x: 32'sh7FFF_FFFF, offset_y: 32'sh7FFF_FFFF,
          offset_z: 32'sh7FFF_FFFF, pitch_angle: 16'sd0, roll_angle: 16'sd0};
    send_request(r);
    corner_q[corner_q.size() - 1] = '{corner_index: 3'd7, corner_x: 32'sh7FFF_FFFF,
                                      corner_y: 32'sh7FFF_FFFF,
                                      corner_z: 32'sh7FFF_FFFF, last_corner: 1'b1};
    for (int n = 0; n < 40; n++) send_request(rand_request());
    drain();

    // Largest boxes: every extent at its top value, which is odd.
    write_reg(bcrpt_pkg::RegBoxWidth, 31'h7FFF_FFFF);
    write_reg(bcrpt_pkg::RegBoxHeight, 31'h7FFF_FFFF);
    write_reg(bcrpt_pkg::RegBoxDepth, 31'h7FFF_FFFF);
    for (int n = 0; n < 40; n++) send_request(rand_request());
    drain();

    // Degenerate box, and a write to an unused index that must change nothing.
    write_reg(bcrpt_pkg::RegBoxWidth, 31'd0);
    write_reg(bcrpt_pkg::RegBoxHeight, 31'd0);
    write_reg(bcrpt_pkg::RegBoxDepth, 31'd0);
    write_reg(bcrpt_pkg::CfgIdxW'(bcrpt_pkg::NumRegs), 31'h5555_5555);
    for (int n = 0; n < 30; n++) send_request(rand_request());
    drain();

    // Odd extents, so every half extent drops a low bit: width 0, height 1.
    write_reg(bcrpt_pkg::RegBoxWidth, 31'd1);
    write_reg(bcrpt_pkg::RegBoxHeight, 31'd3);
    write_reg(bcrpt_pkg::RegBoxDepth, 31'h4000_0001);
    for (int n = 0; n < 30; n++) send_request(rand_request());
    drain();

    // Random box sizes, a new setting for each batch.
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(bcrpt_pkg::RegBoxWidth, 31'($urandom));
      write_reg(bcrpt_pkg::RegBoxHeight, 31'($urandom_range(32'h0100_0000)));
      write_reg(bcrpt_pkg::RegBoxDepth, 31'($urandom));
      for (int n = 0; n < 22; n++) send_request(rand_request());
      drain();
    end

    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #400000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

`default_nettype wire
